[rtl/ovl_pkg.sv]
// Shared definitions for the ordered value list: sizes, request and
// status codes, word structs and the sequencer state type.
// No dependencies.
`default_nettype none

package ovl_pkg;

  // list capacity and derived widths
  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int VAL_W      = 32;
  localparam int POS_W      = 5;

  // request codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;
  localparam logic [1:0] FUNC_EMPTY  = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic        [1:0]       func;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
    logic             is_empty;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_DN,
    ST_SHIFT_UP,
    ST_INS_HEAD,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

[rtl/ovl_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module ovl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/ordered_value_list.sv]
// Ordered value list, head at entry 0, entries kept in one RAM (ovl_ram). One word at
// a time: requests stall until the last result is loaded for output. Insert moves each
// entry up by one from the tail and writes the new value at the head; delete and search
// walk from the head to the first match, and delete then moves later entries down, one
// entry per cycle. Empty queries, full inserts and words on an empty list skip the walk.
// Reset (rst, synchronous) empties the list; entry contents stay undefined.
`default_nettype none

module ordered_value_list (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output      logic          req_stall,
  input  wire ovl_pkg::req_t req,
  output      logic          rsp_valid,
  input  wire logic          rsp_stall,
  output      ovl_pkg::rsp_t rsp
);

  ovl_pkg::state_t state, state_next;

  logic [ovl_pkg::CNT_W-1:0] count, count_next;
  logic [ovl_pkg::CNT_W-1:0] idx, idx_next;
  logic                      more, more_next;
  logic                      pend, pend_next;
  logic [ovl_pkg::IDX_W-1:0] pidx, pidx_next;
  logic                      del, del_next;
  logic [ovl_pkg::VAL_W-1:0] value_r, value_next;
  logic [1:0]                res_status, res_status_next;
  logic [ovl_pkg::POS_W-1:0] res_pos, res_pos_next;

  logic                      ram_we;
  logic [ovl_pkg::IDX_W-1:0] ram_waddr;
  logic [ovl_pkg::VAL_W-1:0] ram_wdata;
  logic [ovl_pkg::IDX_W-1:0] ram_raddr;
  logic [ovl_pkg::VAL_W-1:0] ram_rdata;

  logic [ovl_pkg::CNT_W-1:0] idx_inc;
  logic [ovl_pkg::CNT_W-1:0] pnext;
  logic                      rsp_load;

  assign idx_inc  = idx + ovl_pkg::CNT_W'(1);
  assign pnext    = ovl_pkg::CNT_W'(pidx) + ovl_pkg::CNT_W'(1);
  assign rsp_load = (state == ovl_pkg::ST_FINISH) && (!rsp_valid || !rsp_stall);

  ovl_ram #(
    .WIDTH(ovl_pkg::VAL_W),
    .DEPTH(ovl_pkg::LIST_DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ovl_pkg::ST_IDLE;
      count <= '0;
      more  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      more  <= more_next;
      pend  <= pend_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    pidx       <= pidx_next;
    del        <= del_next;
    value_r    <= value_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
  end

  // output register: load the finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status   <= res_status;
      rsp.position <= res_pos;
      rsp.is_empty <= (count == '0);
    end
  end

  // sequencer: walk the RAM one entry per cycle; read data is used in the cycle after its read is issued
  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    more_next       = more;
    pend_next       = 1'b0;
    pidx_next       = pidx;
    del_next        = del;
    value_next      = value_r;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    ram_we          = 1'b0;
    ram_waddr       = pidx;
    ram_wdata       = ram_rdata;
    ram_raddr       = idx[ovl_pkg::IDX_W-1:0];
    req_stall       = (state != ovl_pkg::ST_IDLE);

    case (state)
      ovl_pkg::ST_IDLE: begin
        if (req_valid) begin
          value_next      = req.value;
          res_status_next = ovl_pkg::STAT_OK;
          res_pos_next    = '0;
          case (req.func)
            ovl_pkg::FUNC_INSERT: begin
              if (count == ovl_pkg::CNT_W'(ovl_pkg::LIST_DEPTH)) begin
                res_status_next = ovl_pkg::STAT_FULL;
                state_next      = ovl_pkg::ST_FINISH;
              end else if (count == '0) begin
                state_next = ovl_pkg::ST_INS_HEAD;
              end else begin
                idx_next   = count - ovl_pkg::CNT_W'(1);
                more_next  = 1'b1;
                state_next = ovl_pkg::ST_SHIFT_UP;
              end
            end
            ovl_pkg::FUNC_DELETE, ovl_pkg::FUNC_SEARCH: begin
              del_next = (req.func == ovl_pkg::FUNC_DELETE);
              if (count == '0) begin
                res_status_next = ovl_pkg::STAT_EMPTY;
                state_next      = ovl_pkg::ST_FINISH;
              end else begin
                idx_next   = '0;
                more_next  = 1'b1;
                state_next = ovl_pkg::ST_SCAN;
              end
            end
            default: begin
              state_next = ovl_pkg::ST_FINISH;
            end
          endcase
        end
      end

      ovl_pkg::ST_SCAN: begin
        // issue the next read
        if (more) begin
          pend_next = 1'b1;
          pidx_next = idx[ovl_pkg::IDX_W-1:0];
          idx_next  = idx_inc;
          more_next = (idx_inc < count);
        end
        // compare the entry read last cycle
        if (pend) begin
          if (ram_rdata == value_r) begin
            pend_next = 1'b0;
            more_next = 1'b0;
            if (!del) begin
              res_pos_next = ovl_pkg::POS_W'(pnext);
              state_next   = ovl_pkg::ST_FINISH;
            end else if (pnext == count) begin
              count_next = count - ovl_pkg::CNT_W'(1);
              state_next = ovl_pkg::ST_FINISH;
            end else begin
              idx_next   = pnext;
              more_next  = 1'b1;
              state_next = ovl_pkg::ST_SHIFT_DN;
            end
          end else if (!more) begin
            res_status_next = ovl_pkg::STAT_NOT_FOUND;
            state_next      = ovl_pkg::ST_FINISH;
          end
        end
      end

      ovl_pkg::ST_SHIFT_DN: begin
        // close the gap: entry i+1 moves to i
        if (more) begin
          pend_next = 1'b1;
          pidx_next = idx[ovl_pkg::IDX_W-1:0];
          idx_next  = idx_inc;
          more_next = (idx_inc < count);
        end
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pidx - ovl_pkg::IDX_W'(1);
          if (!more) begin
            count_next = count - ovl_pkg::CNT_W'(1);
            state_next = ovl_pkg::ST_FINISH;
          end
        end
      end

      ovl_pkg::ST_SHIFT_UP: begin
        // open the head: entry i moves to i+1, walking down from the tail
        if (more) begin
          pend_next = 1'b1;
          pidx_next = idx[ovl_pkg::IDX_W-1:0];
          idx_next  = idx - ovl_pkg::CNT_W'(1);
          more_next = (idx != '0);
        end
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pidx + ovl_pkg::IDX_W'(1);
          if (!more) begin
            state_next = ovl_pkg::ST_INS_HEAD;
          end
        end
      end

      ovl_pkg::ST_INS_HEAD: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = value_r;
        count_next = count + ovl_pkg::CNT_W'(1);
        state_next = ovl_pkg::ST_FINISH;
      end

      ovl_pkg::ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = ovl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ovl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/ovl_checker.sv]
// Port-level checks for ordered_value_list, attached by bind.
// Depends on ovl_pkg.
`default_nettype none

module ovl_assertions (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire ovl_pkg::rsp_t rsp
);

  // hold a stalled result word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while a word is in work");

  // a search position comes only with status ok
  a_pos_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.position != '0) |-> rsp.status == ovl_pkg::STAT_OK)
    else $error("position given with a failing status");

  // empty status means the list is empty; full means it is not
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status != ovl_pkg::STAT_EMPTY || rsp.is_empty) &&
                  (rsp.status != ovl_pkg::STAT_FULL || !rsp.is_empty))
    else $error("is_empty disagrees with status");

endmodule

bind ordered_value_list ovl_assertions u_ovl_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);

`default_nettype wire

[bench/ovl_checker.sv]
// Checker for the ordered value list: watches the request and response channels,
// keeps its own copy of the list, and compares each response word field by field.
// Depends on ovl_pkg for the word structs and the request and status codes.
module ovl_checker
  import ovl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow list, head at index 0
  logic [VAL_W-1:0] list_vals [LIST_DEPTH];
  int               list_len;
  rsp_t             due_rsp [$];
  rsp_t             want;

  task automatic report_mismatch(input string msg);
    if (errors < 50) $display("[%0t] list mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // apply one request word to the shadow list and return the response it owes
  function automatic rsp_t list_op(input req_t w);
    rsp_t o;
    int   hit;
    o = '0;
    o.status = STAT_OK;
    hit = -1;
    for (int i = 0; i < list_len; i++) begin
      if (hit < 0 && list_vals[i] == w.value) hit = i;
    end
    case (w.func)
      FUNC_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          for (int i = list_len; i > 0; i--) list_vals[i] = list_vals[i-1];
          list_vals[0] = w.value;
          list_len++;
        end
      end
      FUNC_DELETE: begin
        if (list_len == 0) begin
          o.status = STAT_EMPTY;
        end else if (hit < 0) begin
          o.status = STAT_NOT_FOUND;
        end else begin
          // close the gap behind the removed entry
          for (int i = hit; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      FUNC_SEARCH: begin
        if (list_len == 0) o.status = STAT_EMPTY;
        else if (hit < 0) o.status = STAT_NOT_FOUND;
        else o.position = POS_W'(hit + 1);
      end
      default: begin
      end
    endcase
    o.is_empty = (list_len == 0);
    return o;
  endfunction

  // check responses first: a response never belongs to a word taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      due_rsp.delete();
      list_len = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp.size() == 0) begin
          report_mismatch($sformatf("response word %p with none outstanding", rsp));
        end else begin
          want = due_rsp.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
          if (rsp.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      rsp.position, want.position));
          if (rsp.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %0b, expected %0b",
                                      rsp.is_empty, want.is_empty));
        end
      end
      if (req_valid && !req_stall) due_rsp.push_back(list_op(req));
    end
    pending <= due_rsp.size();
  end

endmodule

[bench/testbench.sv]
// Top of the ordered value list bench: clock, reset, request stimulus and
// response stall, with the verdict. Depends on ovl_pkg, ordered_value_list
// and ovl_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ovl_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int POOL_N      = 6;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int errors;
  int pending;
  int cycles    = 0;
  int idle_pct  = 0;
  int stall_pct = 0;
  logic [VAL_W-1:0] pool [POOL_N];

  ordered_value_list uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  ovl_checker chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // stall the response side at random
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // offer one request word, with random idle cycles ahead of it; hold until taken
  task automatic put_word(input logic [1:0] f, input logic [VAL_W-1:0] v);
    req_t w;
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    w.func  = f;
    w.value = v;
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // pick a request mix; most values come from a small pool so matches are common
  task automatic random_word(input int ins_pct);
    logic [1:0]       f;
    logic [VAL_W-1:0] v;
    int               r;
    r = $urandom_range(99);
    if (r < ins_pct) f = FUNC_INSERT;
    else if (r < ins_pct + 30) f = FUNC_DELETE;
    else if (r < 92) f = FUNC_SEARCH;
    else f = FUNC_EMPTY;
    if ($urandom_range(3) != 0) v = pool[$urandom_range(POOL_N - 1)];
    else v = $urandom();
    put_word(f, v);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty list: query, delete and search
    put_word(FUNC_EMPTY, 32'hFFFF_FFFF);
    put_word(FUNC_DELETE, 32'h0000_0000);
    put_word(FUNC_SEARCH, 32'h0000_0000);
    // extremes, tail delete, then delete the last remaining value
    put_word(FUNC_INSERT, 32'h8000_0000);
    put_word(FUNC_INSERT, 32'h7FFF_FFFF);
    put_word(FUNC_SEARCH, 32'h7FFF_FFFF);
    put_word(FUNC_DELETE, 32'h8000_0000);
    put_word(FUNC_DELETE, 32'h7FFF_FFFF);
    put_word(FUNC_EMPTY, 32'h0000_0000);
    // fill with duplicates, refuse one more, then first-match search and delete
    for (int k = 0; k < LIST_DEPTH; k++) put_word(FUNC_INSERT, VAL_W'(k % 8));
    put_word(FUNC_INSERT, 32'hFFFF_FFFF);
    put_word(FUNC_SEARCH, 32'h0000_0000);
    put_word(FUNC_DELETE, 32'h0000_0003);
    put_word(FUNC_SEARCH, 32'h0000_0003);
    put_word(FUNC_SEARCH, 32'h0000_0010);

    // random words in phases of idling and stalling, alternating fill and drain
    for (int chunk = 0; chunk < 12; chunk++) begin
      case (chunk % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      for (int p = 0; p < POOL_N; p++) pool[p] = $urandom();
      for (int n = 0; n < 100; n++) random_word((((chunk / 4) + chunk) % 2) ? 55 : 25);
      // after chunk 5, drain every outstanding response before going on
      if (chunk == 5) begin
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
    end

    req_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ovl_pkg.sv
rtl/ovl_ram.sv
rtl/ordered_value_list.sv
rtl/ovl_checker.sv
bench/ovl_checker.sv
bench/testbench.sv
